// ----- hw/rtl/dc2_pkg.sv -----
package dc2_pkg;

  // stream payload widths
  localparam int S_TDATA_W  = 48;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 32;
  localparam int M_TUSER_W  = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // input field widths
  localparam int ADDR_W = 12;
  localparam int VAL_W  = 16;
  localparam int OC_W   = 4;
  localparam int POS_W  = 6;

  // widest flat index before wrapping to the store depth
  localparam int IMG_IDX_W = 19;
  localparam int WGT_IDX_W = 15;

  // request kinds on tuser
  localparam logic [S_TUSER_W-1:0] REQ_WR_SAMPLE = 2'd0;
  localparam logic [S_TUSER_W-1:0] REQ_WR_WEIGHT = 2'd1;
  localparam logic [S_TUSER_W-1:0] REQ_COMPUTE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KERN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD    = 3'd7;

  // operation carried down the tap pipeline
  typedef enum logic [1:0] {
    OP_NONE,
    OP_WR_IMG,
    OP_WR_WGT,
    OP_MAC
  } op_t;

endpackage

// ----- hw/rtl/dc2_ram.sv -----
module dc2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/dc2_mod.sv -----
// wraps a flat index to the store depth: reciprocal multiply, back multiply,
// then one compare and subtract
module dc2_mod #(
  parameter int DEPTH = 4096,
  parameter int XW    = 19
) (
  input  logic                     clk,
  input  logic [XW-1:0]            x,
  output logic [$clog2(DEPTH)-1:0] addr
);

  localparam int AW = $clog2(DEPTH);
  localparam int R  = (2 ** XW) / DEPTH;
  localparam int RW = $clog2(R + 1);
  localparam int PW = XW + RW;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

  logic [XW-1:0] x_q;
  logic [RW-1:0] quot;
  logic [PW-1:0] prod;
  logic [XW-1:0] back;
  logic [XW-1:0] rem_full;
  logic [AW:0]   rem;

  // quotient estimate is exact or one short
  assign prod = PW'(x) * PW'(R);

  always_ff @(posedge clk) begin
    x_q  <= x;
    quot <= prod[PW-1:XW];
  end

  assign back     = XW'(quot) * XW'(DEPTH);
  assign rem_full = x_q - back;

  always_ff @(posedge clk) begin
    rem <= rem_full[AW:0];
  end

  assign addr = (rem >= DEPTH_C) ? AW'(rem - DEPTH_C) : AW'(rem);

endmodule

// ----- hw/rtl/direct_conv2d.sv -----
// direct_conv2d: multi-channel 2d convolution over one nchw image held on chip
//
// input stream (s_axis_*): tuser carries the request kind. sample and weight
// writes go into the image and weight stores, one transaction per cycle while
// idle, and return nothing. a compute transaction names an output channel, row and
// column and returns one transaction on m_axis_*: the saturated q16.16 sum in
// tdata, status in tuser (1 when the channel or position lies outside the output grid).
// configuration (cfg_*) is to be written only while the block is idle; the block does not enforce it.
//
// a compute walks the taps one per cycle through a fixed pipeline: index
// build, wrap to store depth, store read, multiply, accumulate; the single
// store read port sets one tap per cycle. an out-of-grid request skips the
// walk and goes from the check state straight to the output register.
// writes are taken back to back while the block is idle.
//
// reset returns the registers to their defaults and empties the pipeline;
// store contents are not cleared, so a store entry must be written before use.
// when the receiver stalls the result sits in the output register; the next
// request is still taken, and a further result waits until that slot drains.
module direct_conv2d #(
  parameter int IMAGE_WORDS  = 4096,
  parameter int WEIGHT_WORDS = 4096,
  parameter int DATA_WIDTH   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] store_addr, [27:12] sample_value, [31:28] out_channel,
  // [37:32] out_row, [43:38] out_col, [47:44] zero
  input  logic [dc2_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [dc2_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] conv_out
  output logic [dc2_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] status
  output logic [dc2_pkg::M_TUSER_W-1:0]     m_axis_tuser,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dc2_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dc2_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dc2_pkg::*;

  // stored word keeps at most 16 bits of the written value
  localparam int SW     = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int ACCW   = (2 * SW + 12 > 33) ? 2 * SW + 12 : 33;
  localparam int IMG_AW = $clog2(IMAGE_WORDS);
  localparam int WGT_AW = $clog2(WEIGHT_WORDS);
  localparam int IMG_XW = (IMG_IDX_W > IMG_AW + 1) ? IMG_IDX_W : IMG_AW + 1;
  localparam int WGT_XW = (WGT_IDX_W > WGT_AW + 1) ? WGT_IDX_W : WGT_AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_t;

  // configuration registers
  logic [4:0] in_chans;
  logic [4:0] out_chans;
  logic [6:0] img_height;
  logic [6:0] img_width;
  logic [2:0] kern_height;
  logic [2:0] kern_width;
  logic [2:0] step_size;
  logic       zero_pad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_chans    <= 5'd1;
      out_chans   <= 5'd1;
      img_height  <= 7'd8;
      img_width   <= 7'd8;
      kern_height <= 3'd3;
      kern_width  <= 3'd3;
      step_size   <= 3'd1;
      zero_pad    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IN_CHANS:    in_chans    <= cfg_data[4:0];
        CFG_OUT_CHANS:   out_chans   <= cfg_data[4:0];
        CFG_IMG_HEIGHT:  img_height  <= cfg_data[6:0];
        CFG_IMG_WIDTH:   img_width   <= cfg_data[6:0];
        CFG_KERN_HEIGHT: kern_height <= cfg_data[2:0];
        CFG_KERN_WIDTH:  kern_width  <= cfg_data[2:0];
        CFG_STEP_SIZE:   step_size   <= cfg_data[2:0];
        CFG_ZERO_PAD:    zero_pad    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [S_TUSER_W-1:0] req_type;
  logic [ADDR_W-1:0]    store_addr;
  logic [VAL_W-1:0]     sample_value;
  logic [OC_W-1:0]      out_channel;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;

  assign req_type     = s_axis_tuser;
  assign store_addr   = s_axis_tdata[11:0];
  assign sample_value = s_axis_tdata[27:12];
  assign out_channel  = s_axis_tdata[31:28];
  assign out_row      = s_axis_tdata[37:32];
  assign out_col      = s_axis_tdata[43:38];

  state_t state;

  // latched compute request
  logic [OC_W-1:0]  oc_q;
  logic [POS_W-1:0] orow_q;
  logic [POS_W-1:0] ocol_q;

  // per-request geometry, set in the check cycle
  logic signed [10:0] row0;
  logic signed [10:0] col0;
  logic [13:0]        plane;
  logic [8:0]         oc_scaled;
  logic [5:0]         kern_taps;

  // tap walk
  logic [4:0]                 ic;
  logic [2:0]                 kh;
  logic [2:0]                 kw;
  logic [IMG_IDX_W-1:0]       plane_base;
  logic [WGT_IDX_W-1:0]       wgt_lin;

  // result waiting for the output register
  logic [M_TDATA_W-1:0] res_data;
  logic [M_TUSER_W-1:0] res_status;

  // pipeline stage 1: tap or write entering the datapath
  op_t                  op1;
  logic                 last1;
  logic [ADDR_W-1:0]    addr1;
  logic [SW-1:0]        data1;
  logic [IMG_IDX_W-1:0] base1;
  logic [6:0]           ih1;
  logic [6:0]           iw1;
  logic [WGT_IDX_W-1:0] wlin1;

  // check-cycle geometry
  logic [2:0]  stride;
  logic [1:0]  pad_h;
  logic [1:0]  pad_w;
  logic [7:0]  span_h;
  logic [7:0]  span_w;
  logic [8:0]  row_step;
  logic [8:0]  col_step;
  logic        grid_ok;

  assign stride   = (step_size == 3'd0) ? 3'd1 : step_size;
  assign pad_h    = zero_pad ? kern_height[2:1] : 2'd0;
  assign pad_w    = zero_pad ? kern_width[2:1] : 2'd0;
  assign span_h   = 8'(img_height) + 8'({pad_h, 1'b0});
  assign span_w   = 8'(img_width) + 8'({pad_w, 1'b0});
  assign row_step = 9'(orow_q) * 9'(stride);
  assign col_step = 9'(ocol_q) * 9'(stride);
  // row < out_h holds exactly when row*stride + kern fits in the padded span
  assign grid_ok  = (5'(oc_q) < out_chans)
                 && (10'(row_step) + 10'(kern_height) <= 10'(span_h))
                 && (10'(col_step) + 10'(kern_width) <= 10'(span_w));

  // current tap position in the image
  logic signed [10:0] ih;
  logic signed [10:0] iw;
  logic               tap_in;
  logic               tap_last;
  logic               kw_end;
  logic               kh_end;
  logic               empty_sum;

  assign ih       = row0 + $signed(11'(kh));
  assign iw       = col0 + $signed(11'(kw));
  // taps in the padding contribute nothing and skip the store read
  assign tap_in   = !ih[10] && (ih[9:0] < 10'(img_height))
                 && !iw[10] && (iw[9:0] < 10'(img_width));
  assign kw_end   = (kw + 3'd1 == kern_width);
  assign kh_end   = (kh + 3'd1 == kern_height);
  assign tap_last = (ic + 5'd1 == in_chans) && kh_end && kw_end;
  assign empty_sum = (in_chans == 5'd0) || (kern_height == 3'd0) || (kern_width == 3'd0);

  // accumulator and saturation
  logic signed [ACCW-1:0] acc;
  logic                   last7;
  logic                   pos_ovf;
  logic                   neg_ovf;
  logic [M_TDATA_W-1:0]   acc_sat;

  assign pos_ovf = !acc[ACCW-1] && (|acc[ACCW-2:31]);
  assign neg_ovf = acc[ACCW-1] && !(&acc[ACCW-2:31]);
  assign acc_sat = pos_ovf ? 32'h7fff_ffff : (neg_ovf ? 32'h8000_0000 : acc[31:0]);

  assign s_axis_tready = (state == ST_IDLE);

  // sequencer: request decode, tap walk, result hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      op1           <= OP_NONE;
      last1         <= 1'b0;
    end else begin
      op1   <= OP_NONE;
      last1 <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          addr1 <= store_addr;
          data1 <= sample_value[SW-1:0];
          if (s_axis_tvalid) begin
            oc_q   <= out_channel;
            orow_q <= out_row;
            ocol_q <= out_col;
            unique case (req_type)
              REQ_WR_SAMPLE: op1 <= OP_WR_IMG;
              REQ_WR_WEIGHT: op1 <= OP_WR_WGT;
              REQ_COMPUTE:   state <= ST_CHECK;
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          row0      <= $signed(11'(row_step) - 11'(pad_h));
          col0      <= $signed(11'(col_step) - 11'(pad_w));
          plane     <= 14'(img_height) * 14'(img_width);
          oc_scaled <= 9'(oc_q) * 9'(in_chans);
          kern_taps <= 6'(kern_height) * 6'(kern_width);
          if (grid_ok) begin
            state <= ST_SETUP;
          end else begin
            res_data   <= '0;
            res_status <= 1'b1;
            state      <= ST_FINISH;
          end
        end
        ST_SETUP: begin
          ic         <= '0;
          kh         <= '0;
          kw         <= '0;
          plane_base <= '0;
          wgt_lin    <= WGT_IDX_W'(oc_scaled) * WGT_IDX_W'(kern_taps);
          if (empty_sum) begin
            last1 <= 1'b1;
            state <= ST_WAIT;
          end else begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          op1   <= tap_in ? OP_MAC : OP_NONE;
          last1 <= tap_last;
          base1 <= plane_base;
          ih1   <= ih[6:0];
          iw1   <= iw[6:0];
          wlin1 <= wgt_lin;
          // weights are laid out in walk order, so the index just counts up
          wgt_lin <= wgt_lin + WGT_IDX_W'(1);
          if (kw_end) begin
            kw <= '0;
            if (kh_end) begin
              kh         <= '0;
              ic         <= ic + 5'd1;
              plane_base <= plane_base + IMG_IDX_W'(plane);
            end else begin
              kh <= kh + 3'd1;
            end
          end else begin
            kw <= kw + 3'd1;
          end
          if (tap_last) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (last7) begin
            res_data   <= acc_sat;
            res_status <= 1'b0;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_data;
            m_axis_tuser  <= res_status;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // stage 2: flat store indexes
  op_t                  op2;
  logic                 last2;
  logic [SW-1:0]        data2;
  logic [IMG_IDX_W-1:0] ximg2;
  logic [WGT_IDX_W-1:0] xwgt2;
  logic [13:0]          row_off;

  assign row_off = 14'(ih1) * 14'(img_width);

  always_ff @(posedge clk) begin
    ximg2 <= (op1 == OP_WR_IMG) ? IMG_IDX_W'(addr1)
                                : base1 + IMG_IDX_W'(row_off) + IMG_IDX_W'(iw1);
    xwgt2 <= (op1 == OP_WR_WGT) ? WGT_IDX_W'(addr1) : wlin1;
    data2 <= data1;
  end

  // stages 3 and 4: wrap to store depth
  logic [IMG_AW-1:0] img_addr;
  logic [WGT_AW-1:0] wgt_addr;

  dc2_mod #(
    .DEPTH (IMAGE_WORDS),
    .XW    (IMG_XW)
  ) u_img_mod (
    .clk  (clk),
    .x    (IMG_XW'(ximg2)),
    .addr (img_addr)
  );

  dc2_mod #(
    .DEPTH (WEIGHT_WORDS),
    .XW    (WGT_XW)
  ) u_wgt_mod (
    .clk  (clk),
    .x    (WGT_XW'(xwgt2)),
    .addr (wgt_addr)
  );

  op_t           op3;
  op_t           op4;
  op_t           op5;
  op_t           op6;
  logic          last3;
  logic          last4;
  logic          last5;
  logic          last6;
  logic [SW-1:0] data3;
  logic [SW-1:0] data4;

  always_ff @(posedge clk) begin
    data3 <= data2;
    data4 <= data3;
  end

  // stores: write or read at stage 4, read data at stage 5
  logic [SW-1:0] img_rd;
  logic [SW-1:0] wgt_rd;

  dc2_ram #(
    .WIDTH (SW),
    .DEPTH (IMAGE_WORDS)
  ) u_image_store (
    .clk   (clk),
    .we    (op4 == OP_WR_IMG),
    .addr  (img_addr),
    .wdata (data4),
    .rdata (img_rd)
  );

  dc2_ram #(
    .WIDTH (SW),
    .DEPTH (WEIGHT_WORDS)
  ) u_weight_store (
    .clk   (clk),
    .we    (op4 == OP_WR_WGT),
    .addr  (wgt_addr),
    .wdata (data4),
    .rdata (wgt_rd)
  );

  // stage 6: product, stage 7: accumulate
  logic signed [2*SW-1:0] prod;

  always_ff @(posedge clk) begin
    prod <= $signed(img_rd) * $signed(wgt_rd);
    if (state == ST_CHECK) begin
      acc <= '0;
    end else if (op6 == OP_MAC) begin
      acc <= acc + ACCW'(prod);
    end
  end

  // in-order control tags; every transaction passes each stage once
  always_ff @(posedge clk) begin
    if (rst) begin
      op2   <= OP_NONE;
      op3   <= OP_NONE;
      op4   <= OP_NONE;
      op5   <= OP_NONE;
      op6   <= OP_NONE;
      last2 <= 1'b0;
      last3 <= 1'b0;
      last4 <= 1'b0;
      last5 <= 1'b0;
      last6 <= 1'b0;
      last7 <= 1'b0;
    end else begin
      op2   <= op1;
      op3   <= op2;
      op4   <= op3;
      op5   <= op4;
      op6   <= op5;
      last2 <= last1;
      last3 <= last2;
      last4 <= last3;
      last5 <= last4;
      last6 <= last5;
      last7 <= last6;
    end
  end

endmodule
